>>> rtl/core/sng_pkg.sv
// Shared types, constants and character helpers for the short name generator.
package sng_pkg;

  localparam int unsigned SN_LEN      = 11;
  localparam int unsigned SN_BASE_LEN = 8;
  localparam int unsigned SN_EXT_LEN  = 3;

  // Default depth of the queue of finished names between front and back.
  localparam int unsigned SNG_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [3:0] LAST_INDEX = 4'(SN_LEN - 1);

  typedef logic [SN_LEN-1:0][7:0] name_t;

  typedef enum logic [1:0] {
    PH_BASE = 2'd0,
    PH_SKIP = 2'd1,
    PH_EXT  = 2'd2
  } phase_t;

  // Status of the name queue as seen by the front and back parts.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] base_map(input logic [7:0] c);
    if (c >= 8'h20 && c <= 8'h7E) begin
      return upcase(c);
    end
    return CH_TILDE;
  endfunction

  function automatic name_t blank_name();
    name_t n;
    for (int i = 0; i < SN_LEN; i++) begin
      n[i] = CH_SPACE;
    end
    return n;
  endfunction

endpackage

>>> rtl/core/sng_front.sv
// Front part: takes long-name bytes, builds the 8.3 name, hands it to the queue.
module sng_front
  import sng_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic [7:0] ch,
  input  logic      last_char,
  input  q_status_t q_status,
  output logic      full,
  output logic      q_push,
  output name_t     q_name
);

  name_t      short_buf;
  phase_t     phase;
  logic [3:0] base_count;
  logic       too_long;
  logic [1:0] ext_count;

  name_t      short_buf_next;
  phase_t     phase_next;
  logic [3:0] base_count_next;
  logic       too_long_next;
  logic [1:0] ext_count_next;
  name_t      buf_upd;
  logic       accept;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  always_comb begin
    buf_upd         = short_buf;
    phase_next      = phase;
    base_count_next = base_count;
    too_long_next   = too_long;
    ext_count_next  = ext_count;
    if (phase == PH_BASE || phase == PH_SKIP) begin
      if (ch == CH_DOT) begin
        if (too_long) begin
          buf_upd[SN_BASE_LEN-1] = CH_TILDE;
        end
        phase_next = PH_EXT;
      end else if (phase == PH_BASE && base_count < 4'(SN_BASE_LEN)) begin
        buf_upd[base_count] = base_map(ch);
        base_count_next     = base_count + 4'd1;
        if (base_count_next >= 4'(SN_BASE_LEN)) begin
          phase_next = PH_SKIP;
        end
      end else begin
        phase_next    = PH_SKIP;
        too_long_next = 1'b1;
      end
    end else begin
      // The unused phase code behaves as the extension phase.
      if (ext_count < 2'(SN_EXT_LEN)) begin
        buf_upd[4'(SN_BASE_LEN) + {2'b00, ext_count}] = upcase(ch);
        ext_count_next = ext_count + 2'd1;
      end
    end
    short_buf_next = buf_upd;
    if (last_char) begin
      short_buf_next  = blank_name();
      phase_next      = PH_BASE;
      base_count_next = '0;
      too_long_next   = 1'b0;
      ext_count_next  = '0;
    end
  end

  assign q_push = accept && last_char;
  assign q_name = buf_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_buf  <= blank_name();
      phase      <= PH_BASE;
      base_count <= '0;
      too_long   <= 1'b0;
      ext_count  <= '0;
    end else if (accept) begin
      short_buf  <= short_buf_next;
      phase      <= phase_next;
      base_count <= base_count_next;
      too_long   <= too_long_next;
      ext_count  <= ext_count_next;
    end
  end

endmodule

>>> rtl/core/sng_queue.sv
// Small queue of finished short names between the front and back parts.
module sng_queue
  import sng_pkg::*;
#(
  parameter int unsigned DEPTH = SNG_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  name_t     din,
  input  logic      pop,
  output name_t     head,
  output q_status_t status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  name_t           entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("name queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("name queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("name queue count did not shrink on pop");

endmodule

>>> rtl/core/sng_back.sv
// Back part: sends each queued short name out as eleven result bytes.
module sng_back
  import sng_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  name_t      head,
  input  q_status_t  q_status,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_char,
  output logic [3:0] out_index,
  output logic       last_out,
  output logic       q_pop
);

  logic [3:0] idx;
  logic [3:0] idx_next;
  logic       take;

  assign empty     = q_status.empty;
  assign take      = pop && !q_status.empty;
  assign out_char  = head[idx];
  assign out_index = idx;
  assign last_out  = (idx == LAST_INDEX);
  assign q_pop     = take && last_out;

  always_comb begin
    idx_next = idx;
    if (take) begin
      idx_next = last_out ? 4'd0 : idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_INDEX)
    else $error("byte index beyond the short name");

  a_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> (idx == 4'd0))
    else $error("byte index left mid-name with no name queued");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (idx == 4'd0))
    else $error("byte index did not return to zero after a name");

endmodule

>>> rtl/core/short_name_generator.sv
// Top level of the 8.3 short name generator: front, name queue and back.
//
// Input channel: one long-name byte per transaction on ch, with last_char
// high on the final byte. A transaction completes on a rising edge where
// push is high and full is low. Every byte is classified and written into
// the name being built in the cycle it is accepted, so the front takes one
// byte per cycle with no gaps while full is low.
// Result channel: each finished name appears as eleven transactions, bytes
// 0 to 10 in order on out_char with their position on out_index and
// last_out high on byte 10. A byte is on the ports while empty is low and
// is taken on a rising edge where pop is also high.
// Result timing: with the queue empty, the first byte of a name is visible
// the cycle after the transaction carrying last_char. The back part then
// sends one byte per cycle while pop is high.
// Throughput: one input byte per cycle for names of eleven or more bytes
// while pop stays high; shorter names are limited by the eleven result
// bytes per name, taken from a queue of QUEUE_DEPTH finished names.
// Stalls: when the receiver holds pop low, finished names collect in the
// queue. Once it holds QUEUE_DEPTH names, full is high and the front stalls
// on every byte until the back part has sent the last byte of the oldest
// name.
// Reset: rst (synchronous, active high) empties the queue, clears the name
// under construction to spaces and returns the front to the base phase.
module short_name_generator
  import sng_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SNG_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       last_char,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic [3:0] out_index,
  output logic       last_out
);

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  name_t     q_name;
  name_t     q_head;

  // The front finishes one name per transaction that carries last_char.
  sng_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .ch        (ch),
    .last_char (last_char),
    .q_status  (q_status),
    .full      (full),
    .q_push    (q_push),
    .q_name    (q_name)
  );

  // Finished names wait here until the back part has sent all eleven bytes.
  sng_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .din    (q_name),
    .pop    (q_pop),
    .head   (q_head),
    .status (q_status)
  );

  // The back part walks the oldest name byte by byte.
  sng_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_status  (q_status),
    .pop       (pop),
    .empty     (empty),
    .out_char  (out_char),
    .out_index (out_index),
    .last_out  (last_out),
    .q_pop     (q_pop)
  );

endmodule

>>> verif/tb_short_name_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 8.3 short name generator, with random handshake idling.
module tb_short_name_generator;
  import sng_pkg::*;

  // CYCLE_LIMIT leaves room for the slowest correct run, even with the longest
  // sender gap on every byte and the longest receiver stall on every result.
  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_BYTES = 70;
  localparam int SHOWN_ERRORS = 10;
  // After the last expected byte the block should stay quiet. These cycles
  // are enough for one more name to show up if one were produced by mistake.
  localparam int DRAIN_CYCLES = 30;

  // One long-name byte waiting to be sent. If hold is set, the sender waits
  // until every predicted short-name byte has been received before sending it.
  typedef struct packed {
    logic [7:0] code;
    logic       fin;
    logic       hold;
  } name_byte_t;

  // One predicted byte of a short name, as it should appear on the result ports.
  typedef struct packed {
    logic [7:0] chr;
    logic [3:0] pos;
    logic       fin;
  } short_byte_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  logic [7:0] ch        = 8'h00;
  logic       last_char = 1'b0;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_char;
  logic [3:0] out_index;
  logic       last_out;

  // Predictor state: the short name under construction and its progress.
  logic [7:0] nm_buf [SN_LEN];
  phase_t     nm_phase;
  logic [3:0] base_n;
  logic       overlong;
  logic [1:0] ext_n;

  short_byte_t short_expected[$];
  name_byte_t  long_bytes[$];
  logic [7:0]  word[$];

  int bytes_queued;
  int bytes_taken;
  int names_taken;
  int bytes_checked;
  int errors;
  int cycles;
  int push_wait;
  int pop_wait;
  int push_calm;
  int pop_calm;

  short_name_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .ch        (ch),
    .last_char (last_char),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .out_index (out_index),
    .last_out  (last_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Lower-case letters lose bit 5. Every other byte passes through unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) ? (c & 8'hDF) : c;
  endfunction

  function automatic void clear_name();
    foreach (nm_buf[i]) nm_buf[i] = CH_SPACE;
    nm_phase = PH_BASE;
    base_n   = '0;
    overlong = 1'b0;
    ext_n    = '0;
  endfunction

  // Applies one accepted long-name byte to the predicted name. The final byte
  // queues the full eleven-byte short name and starts a fresh one.
  function automatic void absorb_byte(input logic [7:0] c, input logic fin);
    if (nm_phase == PH_EXT) begin
      // A second dot is an ordinary extension character here. Bytes past the
      // third extension character are dropped.
      if (ext_n != 2'd3) begin
        nm_buf[SN_BASE_LEN + ext_n] = fold_case(c);
        ext_n++;
      end
    end else if (c == CH_DOT) begin
      // The truncation mark appears only once a dot shows the base was cut short.
      if (overlong) nm_buf[SN_BASE_LEN - 1] = CH_TILDE;
      nm_phase = PH_EXT;
    end else if (nm_phase == PH_BASE) begin
      nm_buf[base_n] = (c inside {[CH_SPACE:8'h7E]}) ? fold_case(c) : CH_TILDE;
      base_n++;
      if (base_n == 4'(SN_BASE_LEN)) nm_phase = PH_SKIP;
    end else begin
      overlong = 1'b1;
    end
    if (fin) begin
      for (int k = 0; k < SN_LEN; k++) begin
        short_expected.push_back(short_byte_t'{chr: nm_buf[k], pos: 4'(k),
                                               fin: (k == SN_LEN - 1)});
      end
      clear_name();
      names_taken++;
    end
  endfunction

  // Idle lengths: mostly none or short, now and then long. Now and then a
  // calm stretch starts, with no idling for a while.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(15, 40);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_error(input string msg);
    if (errors < SHOWN_ERRORS) $display("ERROR: %s", msg);
    errors++;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) word.push_back(s[i]);
  endfunction

  // Moves the word being built into the send queue as one name, with the
  // final-byte flag on its last byte.
  function automatic void send_word(input bit hold);
    foreach (word[i]) begin
      long_bytes.push_back(name_byte_t'{code: word[i], fin: (i == word.size() - 1),
                                        hold: hold && (i == 0)});
    end
    bytes_queued += word.size();
    word.delete();
  endfunction

  // A base-name character that is never a dot: letters of either case and
  // digits, or any other byte if wild is set.
  function automatic logic [7:0] name_char(input bit wild);
    logic [7:0] c;
    if (wild) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_DOT) c = 8'h2F;
    end else begin
      case ($urandom_range(0, 2))
        0:       c = "a" + 8'($urandom_range(0, 25));
        1:       c = "A" + 8'($urandom_range(0, 25));
        default: c = "0" + 8'($urandom_range(0, 9));
      endcase
    end
    return c;
  endfunction

  // Most random names are well formed: a base, then an optional dot and an
  // extension. Their lengths sometimes pass the eight- and three-character
  // limits. The remaining names are raw noise with frequent dots.
  function automatic void make_random_name(input bit hold);
    int  base_len;
    int  ext_len;
    int  len;
    bit  wild;
    if ($urandom_range(0, 9) < 8) begin
      wild     = ($urandom_range(0, 3) == 0);
      base_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 14);
      for (int i = 0; i < base_len; i++) begin
        word.push_back(name_char(wild && ($urandom_range(0, 2) == 0)));
      end
      if ($urandom_range(0, 9) < 8) begin
        word.push_back(CH_DOT);
        ext_len = $urandom_range(0, 5);
        for (int i = 0; i < ext_len; i++) begin
          word.push_back(wild ? 8'($urandom_range(0, 255)) : name_char(1'b0));
        end
      end
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        word.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : 8'($urandom_range(0, 255)));
      end
    end
    send_word(hold);
  endfunction

  // Driver. When a transaction completes at this edge, its byte goes to the
  // predictor right away. Predictions therefore always come before the
  // results they describe, which can appear at the next edge at the earliest.
  // A byte stalled by full stays on the ports unchanged.
  always @(posedge clk) begin
    name_byte_t nb;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        absorb_byte(ch, last_char);
        bytes_taken++;
        push_wait = pick_gap(push_calm);
      end
      if (push && full) begin
        // Keep the stalled transaction on the ports.
      end else if (push_wait > 0) begin
        push <= 1'b0;
        push_wait--;
      end else if (long_bytes.size() != 0 &&
                   (!long_bytes[0].hold || short_expected.size() == 0)) begin
        nb = long_bytes.pop_front();
        push      <= 1'b1;
        ch        <= nb.code;
        last_char <= nb.fin;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor. Each completed result transaction is compared with the oldest
  // predicted byte. After each one, the receiver may stall for a random time.
  always @(posedge clk) begin
    short_byte_t sb;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        bytes_checked++;
        if (short_expected.size() == 0) begin
          note_error($sformatf("unexpected result: out_char %02h out_index %0d last_out %b",
                               out_char, out_index, last_out));
        end else begin
          sb = short_expected.pop_front();
          if (out_char !== sb.chr || out_index !== sb.pos || last_out !== sb.fin) begin
            note_error($sformatf({"name %0d byte %0d: expected char %02h index %0d last %b,",
                                  " got char %02h index %0d last %b"},
                                 names_taken, sb.pos, sb.chr, sb.pos, sb.fin,
                                 out_char, out_index, last_out));
          end
        end
        pop_wait = pick_gap(pop_calm);
      end
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes still expected",
               cycles, short_expected.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int directed_bytes;
    int name_no;
    clear_name();

    // Overlong base without a dot, with non-printable bytes at both ends of
    // the byte range, the printable edges around '~', and lower-case 'z'.
    word = '{8'h00, 8'h1F, 8'h7E, 8'h7F, 8'h7A, 8'h60, 8'h7B, 8'hFF, 8'h71};
    send_word(1'b0);
    // Overlong base followed by a dot, so position 7 becomes '~'. The
    // extension starts with a raw 0xFF and a second dot, and one more byte
    // than fits is dropped.
    add_text("aBCDEFGHI.");
    word.push_back(8'hFF);
    add_text(".zc");
    send_word(1'b0);
    // Exactly eight base characters, one of them a space, then a trailing dot.
    add_text("a bcdefg.");
    send_word(1'b0);
    // A name that is only a dot.
    add_text(".");
    send_word(1'b0);
    directed_bytes = bytes_queued;

    // Random names. The first one and the seventh, when there is one, wait until all
    // earlier names have come out in full.
    name_no = 0;
    while (bytes_queued < directed_bytes + RANDOM_BYTES) begin
      make_random_name(name_no == 0 || name_no == 6);
      name_no++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != bytes_queued || short_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d names (%0d bytes), covering dot-only, trailing-dot, overlong and",
             names_taken, bytes_taken);
    $display("undotted names. Checked %0d short-name bytes; %0d were wrong or unexpected.",
             bytes_checked, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sng_pkg.sv
rtl/core/sng_front.sv
rtl/core/sng_queue.sv
rtl/core/sng_back.sv
rtl/core/short_name_generator.sv
verif/tb_short_name_generator.sv
